FILE: rtl/stbs_pkg.sv
`default_nettype none

package stbs_pkg;

   // Fixed field widths
   localparam int unsigned VALUE_W  = 64;
   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned INDEX_W  = 10;

   // Request opcodes
   typedef enum logic [OPCODE_W-1:0] {
      OP_START  = 2'd0,
      OP_APPEND = 2'd1,
      OP_SEARCH = 2'd2
   } opcode_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // Command kinds passed from front to back
   typedef enum logic [1:0] {
      CMD_START,
      CMD_APPEND,
      CMD_SEARCH
   } cmd_kind_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [VALUE_W-1:0]  value;
   } req_item_type;

   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] index;
   } rsp_item_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [VALUE_W-1:0] value;
   } cmd_item_type;

endpackage

`default_nettype wire

FILE: rtl/sorted_table_binary_search.sv
`default_nettype none
// Sorted table with binary search. Items are pushed with an opcode: start a new
// table with the value, append the value, or search for the value as a key;
// the fourth opcode is accepted and ignored. Start and append give no response
// unless an append hits a full table (status full, index zero). A search
// responds found with the matching position, or not found. The table must be
// loaded in ascending order; with duplicate keys the first probed match wins.
// A search dispatches its first probe, then probes the table (at most
// floor(log2(entries))+1 probes, 11 for a full 1024-entry table) and then
// posts the result, waiting while the output register is full; the probe rate
// is set by the single registered read port of the table RAM. A two-entry
// queue in front lets items be pushed while a search runs, and one output
// register holds the response until popped.

module sorted_table_binary_search
   import stbs_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   output logic              req_full,
   input  wire req_item_type req_item,
   output logic              rsp_empty,
   output rsp_item_type      rsp_item,
   input  wire logic         rsp_pop
);

   logic         cmd_valid;
   cmd_item_type cmd_item;
   logic         cmd_pop;

   // Accept and classify
   stbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_item  (cmd_item),
      .cmd_pop   (cmd_pop)
   );

   // Table store and search engine
   stbs_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_item  (cmd_item),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item),
      .rsp_pop   (rsp_pop)
   );

endmodule

`default_nettype wire

FILE: rtl/stbs_ram.sv
`default_nettype none

module stbs_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/stbs_front.sv
`default_nettype none

module stbs_front
   import stbs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   output logic              req_full,
   input  wire req_item_type req_item,
   output logic              cmd_valid,
   output cmd_item_type      cmd_item,
   input  wire logic         cmd_pop
);

   localparam int unsigned QUEUE_DEPTH = 2;

   logic [1:0]   fill_ff, fill_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   cmd_item_type slot_ff [QUEUE_DEPTH];

   logic         accept;
   logic         enqueue;
   logic         dequeue;
   logic         known_op;
   cmd_kind_type kind;

   // Classify opcode; the unused code is accepted and dropped here
   always_comb begin
      known_op = 1'b1;
      kind     = CMD_SEARCH;
      unique case (req_item.opcode)
         OP_START:  kind = CMD_START;
         OP_APPEND: kind = CMD_APPEND;
         OP_SEARCH: kind = CMD_SEARCH;
         default:   known_op = 1'b0;
      endcase
   end

   assign req_full = (fill_ff == 2'(QUEUE_DEPTH));
   assign accept   = req_push && !req_full;
   assign enqueue  = accept && known_op;
   assign dequeue  = cmd_pop && cmd_valid;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = enqueue ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = dequeue ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (enqueue && !dequeue) begin
         fill_in = fill_ff + 2'd1;
      end else if (!enqueue && dequeue) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Payload slots
   always_ff @(posedge clock) begin
      if (enqueue) begin
         slot_ff[wr_ptr_ff] <= '{kind: kind, value: req_item.value};
      end
   end

   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd_item  = slot_ff[rd_ptr_ff];

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'(QUEUE_DEPTH))
      else $error("front queue overfilled");

   a_drop_unknown: assert property (@(posedge clock) disable iff (reset)
      (accept && !known_op && !dequeue) |=> (fill_ff == $past(fill_ff)))
      else $error("unknown opcode reached the queue");

endmodule

`default_nettype wire

FILE: rtl/stbs_back.sv
`default_nettype none

module stbs_back
   import stbs_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         cmd_valid,
   input  wire cmd_item_type cmd_item,
   output logic              cmd_pop,
   output logic              rsp_empty,
   output rsp_item_type      rsp_item,
   input  wire logic         rsp_pop
);

   localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);

   back_state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;     // exclusive upper bound
   logic [ADDR_W-1:0]  mid_ff, mid_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   rsp_item_type       res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_ff, rsp_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic               res_push;
   logic               slot_free;

   stbs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd_item.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free = !rsp_valid_ff || rsp_pop;

   // Sequencer: store ops, probe loop, result hand-off
   always_comb begin
      logic [CNT_W:0]    sum;
      logic [ADDR_W-1:0] mid_next;
      logic [CNT_W-1:0]  lo_next;
      logic [CNT_W-1:0]  hi_next;

      state_in = state_ff;
      count_in = count_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      key_in   = key_ff;
      res_in   = res_ff;
      cmd_pop  = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = count_ff[ADDR_W-1:0];
      rd_en    = 1'b0;
      rd_addr  = mid_ff;
      res_push = 1'b0;
      sum      = '0;
      mid_next = '0;
      lo_next  = lo_ff;
      hi_next  = hi_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               key_in  = cmd_item.value;
               unique case (cmd_item.kind)
                  CMD_START: begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     count_in = CNT_W'(1);
                  end
                  CMD_APPEND: begin
                     if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        res_in   = '{status: STATUS_FULL, index: '0};
                        state_in = ST_DONE;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_SEARCH: begin
                     lo_in = '0;
                     hi_in = count_ff;
                     if (count_ff == '0) begin
                        res_in   = '{status: STATUS_NOT_FOUND, index: '0};
                        state_in = ST_DONE;
                     end else begin
                        sum      = {1'b0, count_ff} - (CNT_W+1)'(1);
                        mid_next = ADDR_W'(sum[CNT_W:1]);
                        rd_en    = 1'b1;
                        rd_addr  = mid_next;
                        mid_in   = mid_next;
                        state_in = ST_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SEARCH: begin
            // rd_data holds the entry at mid_ff
            if (key_ff == rd_data) begin
               res_in   = '{status: STATUS_FOUND, index: INDEX_W'(mid_ff)};
               state_in = ST_DONE;
            end else begin
               if (key_ff > rd_data) begin
                  lo_next = CNT_W'(mid_ff) + CNT_W'(1);
               end else begin
                  hi_next = CNT_W'(mid_ff);
               end
               lo_in = lo_next;
               hi_in = hi_next;
               if (lo_next < hi_next) begin
                  sum      = {1'b0, lo_next} + {1'b0, hi_next} - (CNT_W+1)'(1);
                  mid_next = ADDR_W'(sum[CNT_W:1]);
                  rd_en    = 1'b1;
                  rd_addr  = mid_next;
                  mid_in   = mid_next;
               end else begin
                  res_in   = '{status: STATUS_NOT_FOUND, index: '0};
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (slot_free) begin
               res_push = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_push) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_ff;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      key_ff <= key_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_bounds_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (lo_ff < hi_ff && CNT_W'(mid_ff) < hi_ff))
      else $error("probe outside search bounds");

   a_start_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && cmd_valid && cmd_item.kind == CMD_START)
      |=> (count_ff == CNT_W'(1)))
      else $error("start did not reset the table");

   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && res_ff.status == STATUS_FOUND)
      |-> (CNT_W'(mid_ff) < count_ff))
      else $error("found index beyond loaded entries");

endmodule

`default_nettype wire
